// ===== sv/assert_macros.svh =====
// Assertion macros for the descriptor ring queue.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
// Property must hold on every clock edge outside reset.
`define DRQ_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Property must never hold outside reset.
`define DRQ_ASSERT_NEVER(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) !(prop)) else $error(msg);
`else
`define DRQ_ASSERT(name, clk, rst_n, prop, msg)
`define DRQ_ASSERT_NEVER(name, clk, rst_n, prop, msg)
`endif

`endif

// ===== sv/drq_pkg.sv =====
// Shared types, constants and helpers for the descriptor ring queue.
// No dependencies; used by the controller, datapath and top level.
`default_nettype none

package drq_pkg;

  // Ring storage
  localparam int DEPTH  = 32;
  localparam int IDX_W  = $clog2(DEPTH);
  localparam int LG_W   = 4;
  localparam int CFG_W  = 3;
  localparam int SLOT_W = 5;
  localparam int CNT_W  = 6;
  localparam int PTR_W  = 32;

  localparam logic [CFG_W-1:0] CFG_RESET = 3'd5;
  localparam logic [CNT_W-1:0] CNT_MAX   = {CNT_W{1'b1}};

  typedef enum logic [1:0] {
    OP_PUT    = 2'd0,
    OP_GET    = 2'd1,
    OP_GLANCE = 2'd2,
    OP_FIND   = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_WAIT,
    ST_SCAN
  } state_e;

  // Memory read address source
  typedef enum logic [1:0] {
    RD_NONE,
    RD_HEAD,
    RD_FIRST,
    RD_NEXT
  } rd_sel_e;

  // Result register load source
  typedef enum logic [1:0] {
    RES_NONE,
    RES_PUT,
    RES_MEM,
    RES_FAIL
  } res_sel_e;

  typedef struct packed {
    logic [63:0] mirror_addr;
    logic [63:0] label;
    logic [31:0] command;
    logic [31:0] vf_number;
    logic [63:0] bus_addr;
    logic [31:0] seq;
  } desc_t;

  typedef struct packed {
    logic     latch;
    logic     write;
    rd_sel_e  rd_sel;
    res_sel_e res_sel;
    logic     bump_wr;
    logic     bump_rd;
  } ctrl_cmd_t;

  typedef struct packed {
    opcode_e op;
    logic    full;
    logic    empty;
    logic    match;
    logic    scan_last;
  } ctrl_status_t;

  // Capacity log2 clamped to 1..log2(DEPTH)
  function automatic logic [LG_W-1:0] clamp_lg(input logic [CFG_W-1:0] cfg);
    logic [LG_W-1:0] ext;
    ext = {{(LG_W-CFG_W){1'b0}}, cfg};
    if (ext == '0) begin
      return LG_W'(1);
    end else if (ext > LG_W'(IDX_W)) begin
      return LG_W'(IDX_W);
    end
    return ext;
  endfunction

  // Ring slot mapped onto the result field width
  function automatic logic [SLOT_W-1:0] slot_field(input logic [IDX_W-1:0] idx);
    logic [SLOT_W+IDX_W-1:0] ext;
    ext = {{SLOT_W{1'b0}}, idx};
    return ext[SLOT_W-1:0];
  endfunction

  // Occupancy, saturated to the field width
  function automatic logic [CNT_W-1:0] count_field(input logic [PTR_W-1:0] diff);
    if (diff > PTR_W'(CNT_MAX)) begin
      return CNT_MAX;
    end
    return diff[CNT_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== sv/drq_ctrl.sv =====
// Controller state machine for the descriptor ring queue.
// Depends on drq_pkg; drives datapath commands from datapath status.
`default_nettype none

module drq_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  drq_pkg::ctrl_status_t status_i,
  output drq_pkg::ctrl_cmd_t    cmd_o,
  output logic                  busy_o
);
  import drq_pkg::*;

  state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) state_d = ST_EXEC;
      end
      ST_EXEC: begin
        unique case (status_i.op)
          OP_PUT:           state_d = ST_IDLE;
          OP_GET, OP_GLANCE: state_d = status_i.empty ? ST_IDLE : ST_WAIT;
          OP_FIND:          state_d = ST_SCAN;
          default:          state_d = ST_IDLE;
        endcase
      end
      ST_WAIT: begin
        state_d = ST_IDLE;
      end
      ST_SCAN: begin
        if (status_i.match || status_i.scan_last) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Command outputs
  always_comb begin
    cmd_o         = '0;
    cmd_o.rd_sel  = RD_NONE;
    cmd_o.res_sel = RES_NONE;
    busy_o        = (state_q != ST_IDLE);
    unique case (state_q)
      ST_IDLE: begin
        cmd_o.latch = start_i;
      end
      ST_EXEC: begin
        unique case (status_i.op)
          OP_PUT: begin
            if (status_i.full) begin
              cmd_o.res_sel = RES_FAIL;
            end else begin
              cmd_o.write   = 1'b1;
              cmd_o.bump_wr = 1'b1;
              cmd_o.res_sel = RES_PUT;
            end
          end
          OP_GET, OP_GLANCE: begin
            if (status_i.empty) begin
              cmd_o.res_sel = RES_FAIL;
            end else begin
              cmd_o.rd_sel = RD_HEAD;
            end
          end
          OP_FIND: begin
            cmd_o.rd_sel = RD_FIRST;
          end
          default: cmd_o.res_sel = RES_FAIL;
        endcase
      end
      ST_WAIT: begin
        cmd_o.res_sel = RES_MEM;
        cmd_o.bump_rd = (status_i.op == OP_GET);
      end
      ST_SCAN: begin
        // Compare the slot fetched last cycle; finish on a match or at the last slot, else fetch the next one
        if (status_i.match) begin
          cmd_o.res_sel = RES_MEM;
        end else if (status_i.scan_last) begin
          cmd_o.res_sel = RES_FAIL;
        end else begin
          cmd_o.rd_sel = RD_NEXT;
        end
      end
      default: cmd_o = '0;
    endcase
  end

endmodule

`default_nettype wire

// ===== sv/drq_dp.sv =====
// Datapath of the descriptor ring queue: counters, ring memory, result registers.
// Depends on drq_pkg; commanded by drq_ctrl.
`default_nettype none

module drq_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [drq_pkg::CFG_W-1:0]     cfg_wdata_i,
  input  logic [1:0]                    opcode_i,
  input  drq_pkg::desc_t                entry_i,
  input  drq_pkg::ctrl_cmd_t            cmd_i,
  output drq_pkg::ctrl_status_t         status_o,
  output logic                          done_o,
  output logic                          success_o,
  output drq_pkg::desc_t                result_o,
  output logic [drq_pkg::SLOT_W-1:0]    slot_index_o,
  output logic [drq_pkg::CNT_W-1:0]     entry_count_o
);
  import drq_pkg::*;

  logic [CFG_W-1:0] cfg_q;
  logic [PTR_W-1:0] wr_q, rd_q;
  logic [DEPTH-1:0] valid_q;
  desc_t            mem [DEPTH];
  opcode_e          op_q;
  desc_t            fld_q;
  desc_t            rdata_q;
  logic             rvld_q;
  logic [IDX_W-1:0] raddr_q, raddr_d;
  desc_t            res_q;
  logic             res_ok_q;
  logic [IDX_W-1:0] res_slot_q;
  logic             done_q;

  logic [LG_W-1:0]  lg;
  logic [IDX_W:0]   cap;
  logic [IDX_W:0]   cap_m1;
  logic [IDX_W-1:0] mask;
  logic [PTR_W-1:0] diff;
  logic [IDX_W-1:0] wr_slot, head_slot;
  desc_t            rdata_eff;

  // Capacity and ring pointers
  assign lg        = clamp_lg(cfg_q);
  assign cap       = (IDX_W+1)'(1) << lg;
  assign cap_m1    = cap - (IDX_W+1)'(1);
  assign mask      = cap_m1[IDX_W-1:0];
  assign diff      = wr_q - rd_q;
  assign wr_slot   = wr_q[IDX_W-1:0] & mask;
  assign head_slot = rd_q[IDX_W-1:0] & mask;
  assign rdata_eff = rvld_q ? rdata_q : '0;

  // Status toward the controller
  assign status_o.op        = op_q;
  assign status_o.full      = !(diff < PTR_W'(cap));
  assign status_o.empty     = (wr_q == rd_q);
  assign status_o.match     = (rdata_eff.seq == fld_q.seq);
  assign status_o.scan_last = (raddr_q == mask);

  // Configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else if (cfg_we_i) begin
      cfg_q <= cfg_wdata_i;
    end
  end

  // Free-running counters, slot valid bits, result strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      valid_q <= '0;
      done_q  <= 1'b0;
    end else begin
      if (cmd_i.bump_wr) wr_q <= wr_q + PTR_W'(1);
      if (cmd_i.bump_rd) rd_q <= rd_q + PTR_W'(1);
      if (cmd_i.write)   valid_q[wr_slot] <= 1'b1;
      done_q <= (cmd_i.res_sel != RES_NONE);
    end
  end

  // Transaction capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      op_q  <= opcode_e'(opcode_i);
      fld_q <= entry_i;
    end
  end

  // Read address select
  always_comb begin
    unique case (cmd_i.rd_sel)
      RD_HEAD:  raddr_d = head_slot;
      RD_FIRST: raddr_d = '0;
      RD_NEXT:  raddr_d = raddr_q + IDX_W'(1);
      default:  raddr_d = raddr_q;
    endcase
  end

  // Ring memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (cmd_i.write) begin
      mem[wr_slot] <= fld_q;
    end
    if (cmd_i.rd_sel != RD_NONE) begin
      rdata_q <= mem[raddr_d];
      rvld_q  <= valid_q[raddr_d];
      raddr_q <= raddr_d;
    end
  end

  // Result registers
  always_ff @(posedge clk_i) begin
    unique case (cmd_i.res_sel)
      RES_PUT: begin
        res_q      <= fld_q;
        res_ok_q   <= 1'b1;
        res_slot_q <= wr_slot;
      end
      RES_MEM: begin
        res_q      <= rdata_eff;
        res_ok_q   <= 1'b1;
        res_slot_q <= raddr_q;
      end
      RES_FAIL: begin
        res_q      <= '0;
        res_ok_q   <= 1'b0;
        res_slot_q <= '0;
      end
      default: ;
    endcase
  end

  assign done_o        = done_q;
  assign success_o     = res_ok_q;
  assign result_o      = res_q;
  assign slot_index_o  = slot_field(res_slot_q);
  assign entry_count_o = count_field(diff);

endmodule

`default_nettype wire

// ===== sv/descriptor_ring_queue_top.sv =====
// Channel   | Handshake              | Payload
// command   | start / busy           | opcode_i, entry_*_i
// result    | done_o (1-cycle pulse) | success_o, out_*_o, slot_index_o, entry_count_o
// config    | cfg_we_i               | cfg_wdata_i (capacity_log2)
//
// A transaction is taken when start is high and busy is low. A put ends in EXEC;
// a get/glance reads the head slot in EXEC, loads it in WAIT (fails at once if empty);
// a find reads slots in turn up to the ring capacity through the single read port.
// done_o pulses while busy is low, so the next command may be taken in the same
// cycle. Reset (rst_ni low, async) empties the ring and sets capacity to 32.
// The result side has no back-pressure.
// Depends on drq_pkg, drq_ctrl, drq_dp and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module descriptor_ring_queue_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    opcode_i,
  input  logic [63:0]                   entry_mirror_addr_i,
  input  logic [63:0]                   entry_label_i,
  input  logic [31:0]                   entry_command_i,
  input  logic [31:0]                   entry_vf_number_i,
  input  logic [63:0]                   entry_bus_addr_i,
  input  logic [31:0]                   entry_seq_i,
  input  logic                          cfg_we_i,
  input  logic [drq_pkg::CFG_W-1:0]     cfg_wdata_i,
  output logic                          done_o,
  output logic                          success_o,
  output logic [63:0]                   out_mirror_addr_o,
  output logic [63:0]                   out_label_o,
  output logic [31:0]                   out_command_o,
  output logic [31:0]                   out_vf_number_o,
  output logic [63:0]                   out_bus_addr_o,
  output logic [31:0]                   out_seq_o,
  output logic [drq_pkg::SLOT_W-1:0]    slot_index_o,
  output logic [drq_pkg::CNT_W-1:0]     entry_count_o
);
  import drq_pkg::*;

  ctrl_cmd_t    cmd;
  ctrl_status_t status;
  desc_t        entry;
  desc_t        result;

  // Bundle the command payload
  assign entry.mirror_addr = entry_mirror_addr_i;
  assign entry.label       = entry_label_i;
  assign entry.command     = entry_command_i;
  assign entry.vf_number   = entry_vf_number_i;
  assign entry.bus_addr    = entry_bus_addr_i;
  assign entry.seq         = entry_seq_i;

  drq_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .status_i (status),
    .cmd_o    (cmd),
    .busy_o   (busy)
  );

  drq_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .opcode_i      (opcode_i),
    .entry_i       (entry),
    .cmd_i         (cmd),
    .status_o      (status),
    .done_o        (done_o),
    .success_o     (success_o),
    .result_o      (result),
    .slot_index_o  (slot_index_o),
    .entry_count_o (entry_count_o)
  );

  // Unbundle the result payload
  assign out_mirror_addr_o = result.mirror_addr;
  assign out_label_o       = result.label;
  assign out_command_o     = result.command;
  assign out_vf_number_o   = result.vf_number;
  assign out_bus_addr_o    = result.bus_addr;
  assign out_seq_o         = result.seq;

  // Checks
  `DRQ_ASSERT(a_accept_busy, clk_i, rst_ni, (start && !busy) |=> busy, "accept without busy")
  `DRQ_ASSERT_NEVER(a_done_busy, clk_i, rst_ni, done_o && busy, "result strobe while busy")
  `DRQ_ASSERT(a_fail_slot, clk_i, rst_ni, done_o && !success_o |-> slot_index_o == '0, "fail slot")
  `DRQ_ASSERT(a_count_max, clk_i, rst_ni, entry_count_o <= CNT_W'(DEPTH), "count above depth")

endmodule

`default_nettype wire
